FILE: src/b64lw_pkg.sv
// shared types, constants and the alphabet function for the line-wrapped base64 encoder
package b64lw_pkg;

  localparam int unsigned LineLimit = 60;
  localparam logic [7:0]  CharNl    = 8'h0a;
  localparam logic [7:0]  CharPad   = 8'h3d;
  localparam logic [7:0]  CharPlus  = 8'h2b;
  localparam logic [7:0]  CharSlash = 8'h2f;

  typedef struct packed {
    logic [5:0] s0;
    logic [5:0] s1;
    logic [5:0] s2;
    logic [5:0] s3;
    logic [1:0] nbytes;
    logic       nl;
    logic       eot;
  } grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

endpackage

FILE: src/b64lw_front.sv
// front end: gathers bytes into groups, tracks line fill and pushes encoded groups
module b64lw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output b64lw_pkg::grp_t    q_wdata_o
);
  import b64lw_pkg::*;

  logic [1:0]  phase_q, phase_d, phase;
  logic [15:0] held_q, held_d;
  logic [6:0]  line_q, line_d;
  logic        acc;
  logic [7:0]  b0, b1, b2;
  logic        nl;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign phase      = (phase_q > 2'd2) ? 2'd2 : phase_q;
  assign q_push_o   = acc && (end_of_data_i || phase == 2'd2);
  assign nl         = ({1'b0, line_q} + 8'd4) > 8'(LineLimit);

  always_comb begin
    unique case (phase)
      2'd0: begin
        b0 = in_byte_i; b1 = 8'h00; b2 = 8'h00;
      end
      2'd1: begin
        b0 = held_q[15:8]; b1 = in_byte_i; b2 = 8'h00;
      end
      default: begin
        b0 = held_q[15:8]; b1 = held_q[7:0]; b2 = in_byte_i;
      end
    endcase
  end

  always_comb begin
    q_wdata_o.s0     = b0[7:2];
    q_wdata_o.s1     = {b0[1:0], b1[7:4]};
    q_wdata_o.s2     = {b1[3:0], b2[7:6]};
    q_wdata_o.s3     = b2[5:0];
    q_wdata_o.nbytes = phase + 2'd1;
    q_wdata_o.nl     = nl;
    q_wdata_o.eot    = end_of_data_i;
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    line_d  = line_q;
    if (q_push_o) begin
      phase_d = 2'd0;
      held_d  = 16'h0000;
      if (end_of_data_i) begin
        line_d = 7'd0;
      end else if (nl) begin
        line_d = 7'd4;
      end else begin
        line_d = line_q + 7'd4;
      end
    end else if (acc) begin
      phase_d = phase + 2'd1;
      if (phase == 2'd0) begin
        held_d = {in_byte_i, 8'h00};
      end else begin
        held_d = {held_q[15:8], in_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= 16'h0000;
      line_q  <= 7'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      line_q  <= line_d;
    end
  end

endmodule

FILE: src/b64lw_fifo.sv
// two-entry queue of encoded groups between front and back end
module b64lw_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64lw_pkg::grp_t    wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output b64lw_pkg::grp_t    rdata_o,
  output logic               empty_o
);
  import b64lw_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/b64lw_back.sv
// back end: walks each queued group and drives one character per cycle into the output register when not stalled
module b64lw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64lw_pkg::grp_t    q_rdata_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               run_last_o,
  output logic               end_of_text_o
);
  import b64lw_pkg::*;

  logic [2:0] idx_q;
  logic [1:0] k;
  logic       load, fire, step_last;
  logic [7:0] ch;
  logic       valid_q;
  logic [7:0] char_q;
  logic       run_last_q, eot_q;

  assign load      = !valid_q || !out_stall_i;
  assign fire      = load && !q_empty_i;
  assign k         = 2'(idx_q - {2'b00, q_rdata_i.nl});
  assign step_last = idx_q == (q_rdata_i.nl ? 3'd4 : 3'd3);
  assign q_pop_o   = fire && step_last;

  always_comb begin
    if (q_rdata_i.nl && idx_q == 3'd0) begin
      ch = CharNl;
    end else begin
      case (k)
        2'd0:    ch = b64_char(q_rdata_i.s0);
        2'd1:    ch = b64_char(q_rdata_i.s1);
        2'd2:    ch = (q_rdata_i.nbytes >= 2'd2) ? b64_char(q_rdata_i.s2) : CharPad;
        default: ch = (q_rdata_i.nbytes == 2'd3) ? b64_char(q_rdata_i.s3) : CharPad;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= fire;
      if (fire) begin
        idx_q <= step_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      char_q     <= ch;
      run_last_q <= step_last;
      eot_q      <= step_last && q_rdata_i.eot;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign run_last_o    = run_last_q;
  assign end_of_text_o = eot_q;

endmodule

FILE: src/base64_line_wrapped_encoder_unit.sv
// top level of the line-wrapped base64 encoder
// Streaming base64 encoder: bytes arrive one per request with end_of_data_i on the last
// byte of a message; every completed group of three bytes, and the short final group,
// leaves as four characters (padded with '=' at the end), with a newline put before any
// group that would take the line past 60 characters. The input takes one byte per cycle
// as long as the two-entry group queue has room; the output port moves one character per
// cycle while out_stall_i is low, and that single character output sets the sustained
// rate. A completed group is written into the group queue, and its first character then
// goes into the back end's output register.
module base64_line_wrapped_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       end_of_text_o
);
  import b64lw_pkg::*;

  grp_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_empty;

  b64lw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_data_i (end_of_data_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_wdata_o     (q_wdata)
  );

  b64lw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  b64lw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_rdata_i     (q_rdata),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule

FILE: sim/b64_text_sb_pkg.sv
// scoreboard class that predicts and checks the characters of the line-wrapped base64 encoder
package b64_text_sb_pkg;

  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       end_of_text;
  } b64_char_t;

  class b64_text_scoreboard;
    logic [1:0]  group_phase;
    logic [15:0] held_bytes;
    logic [6:0]  line_used;
    b64_char_t   expected_chars[$];
    int unsigned mismatches;
    int unsigned chars_seen;
    string       alphabet;

    function new();
      group_phase = 2'd0;
      held_bytes  = 16'h0000;
      line_used   = 7'd0;
      mismatches  = 0;
      chars_seen  = 0;
      alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function logic [7:0] symbol(logic [5:0] v);
      return alphabet[v];
    endfunction

    function void push_char(logic [7:0] ch, logic rl, logic eot);
      b64_char_t c;
      c.ch          = ch;
      c.run_last    = rl;
      c.end_of_text = eot;
      expected_chars.push_back(c);
    endfunction

    // predict the characters caused by one accepted request
    function void note_request(logic [7:0] b, logic eod);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] c2;
      logic [7:0] c3;
      if (!eod && group_phase < 2'd2) begin
        if (group_phase == 2'd0) begin
          held_bytes = {b, 8'h00};
        end else begin
          held_bytes[7:0] = b;
        end
        group_phase = group_phase + 2'd1;
        return;
      end
      b0 = (group_phase == 2'd0) ? b : held_bytes[15:8];
      b1 = (group_phase == 2'd0) ? 8'h00 : ((group_phase == 2'd1) ? b : held_bytes[7:0]);
      b2 = (group_phase == 2'd2) ? b : 8'h00;
      c2 = (group_phase >= 2'd1) ? symbol({b1[3:0], b2[7:6]}) : CharPad;
      c3 = (group_phase == 2'd2) ? symbol(b2[5:0]) : CharPad;
      if (int'(line_used) + 4 > int'(LineLimit)) begin
        push_char(CharNl, 1'b0, 1'b0);
        line_used = 7'd4;
      end else begin
        line_used = line_used + 7'd4;
      end
      push_char(symbol(b0[7:2]), 1'b0, 1'b0);
      push_char(symbol({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
      push_char(c2, 1'b0, 1'b0);
      push_char(c3, 1'b1, eod);
      group_phase = 2'd0;
      held_bytes  = 16'h0000;
      if (eod) begin
        line_used = 7'd0;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) begin
        $display("mismatch at char %0d: %s", chars_seen, what);
      end
    endtask

    task check_result(logic [7:0] ch, logic rl, logic eot);
      b64_char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h", ch));
      end else begin
        want = expected_chars.pop_front();
        if (ch !== want.ch) begin
          report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", ch, want.ch));
        end
        if (rl !== want.run_last) begin
          report_mismatch($sformatf("run_last %b, want %b", rl, want.run_last));
        end
        if (eot !== want.end_of_text) begin
          report_mismatch($sformatf("end_of_text %b, want %b", eot, want.end_of_text));
        end
      end
      chars_seen++;
    endtask

    function int unsigned pending();
      return expected_chars.size();
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
// top of the testbench for the line-wrapped base64 encoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64_text_sb_pkg::*;

  typedef logic [7:0] msg_bytes_t[$];

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TargetBytes = 310;
  localparam int unsigned IdlePercent = 38;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte     = 8'h00;
  logic       end_of_data = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_char;
  logic       run_last;
  logic       end_of_text;

  logic        quiet      = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  b64_text_scoreboard sb;

  base64_line_wrapped_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .in_byte_i     (in_byte),
    .end_of_data_i (end_of_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_char_o    (out_char),
    .run_last_o    (run_last),
    .end_of_text_o (end_of_text)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid    = 1'b1;
    in_byte     = b;
    end_of_data = eod;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_request(b, eod);
    bytes_sent++;
  endtask

  task automatic send_message(input msg_bytes_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_random_message(input int unsigned len);
    msg_bytes_t msg;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: msg.push_back(8'h00);
        1: msg.push_back(8'hff);
        default: msg.push_back(8'($urandom_range(255)));
      endcase
    end
    send_message(msg);
  endtask

  always @(negedge clk_i) begin
    out_stall = !quiet && ($urandom_range(99) < IdlePercent);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_result(out_char, run_last, end_of_text);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    msg_bytes_t  msg;
    int unsigned pick;
    int unsigned len;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // short groups, byte extremes, '+' and '/' and a full group before a short one
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'hff};
    send_message(msg);
    msg = '{8'hff, 8'h00};
    send_message(msg);
    msg = '{8'h00, 8'hff};
    send_message(msg);
    msg = '{8'hfb, 8'hef, 8'hbe};
    send_message(msg);
    msg = '{8'hff, 8'hff, 8'hff};
    send_message(msg);
    msg = '{8'h00, 8'h00, 8'h00, 8'h4d};
    send_message(msg);
    msg = '{8'h4d, 8'h61, 8'h6e, 8'h4d, 8'h61};
    send_message(msg);

    while (bytes_sent < TargetBytes) begin
      quiet = (bytes_sent >= 120) && (bytes_sent < 200);
      pick  = $urandom_range(99);
      if (pick < 75) begin
        len = $urandom_range(1, 20);
      end else if (pick < 93) begin
        len = $urandom_range(40, 70);
      end else begin
        len = $urandom_range(90, 130);
      end
      if (len > TargetBytes - bytes_sent) begin
        len = TargetBytes - bytes_sent;
      end
      send_random_message(len);
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
